>>> rtl/upf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upf_pkg: shared types and constants of the udp source port payload filter
// Item structs for both channels, the record passed from the parser to the
// emitter, verdict and kind codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package upf_pkg;

  // default build parameters
  localparam int PAYLOAD_MAX_DEFAULT       = 512;
  localparam int LINK_HEADER_BYTES_DEFAULT = 14;
  localparam int QUEUE_DEPTH_DEFAULT       = 4;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_PORT     = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_PROTOCOL = 1'd1;
  localparam logic [15:0] MATCH_PORT_RESET     = 16'd53;
  localparam logic [7:0]  MATCH_PROTOCOL_RESET = 8'd17;

  // result item kinds
  localparam logic ITEM_PAYLOAD = 1'b0;
  localparam logic ITEM_VERDICT = 1'b1;

  // end-of-frame verdicts
  localparam logic [2:0] VERDICT_ACCEPTED   = 3'd0;
  localparam logic [2:0] VERDICT_SHORT      = 3'd1;
  localparam logic [2:0] VERDICT_PROTOCOL   = 3'd2;
  localparam logic [2:0] VERDICT_HDR_LENGTH = 3'd3;
  localparam logic [2:0] VERDICT_PORT       = 3'd4;
  localparam logic [2:0] VERDICT_EMPTY      = 3'd5;
  localparam logic [2:0] VERDICT_TRUNCATED  = 3'd6;

  // one input item
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } frame_t;

  // one result item
  typedef struct packed {
    logic       item_kind;
    logic [7:0] payload_byte;
    logic [2:0] verdict;
    logic [8:0] payload_length;
    logic       run_last;
  } result_t;

  // what one frame byte produced: a payload byte, a verdict, or both
  typedef struct packed {
    logic       has_payload;
    logic [7:0] payload_byte;
    logic       has_verdict;
    logic [2:0] verdict;
    logic [8:0] payload_length;
  } rec_t;

  // head of the record queue as seen by the emitter
  typedef struct packed {
    logic valid;
    rec_t rec;
  } head_t;

endpackage
`default_nettype wire

>>> rtl/upf_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upf_parser: frame parser and classifier
// Tracks the byte position, captures header fields, decides for each byte
// whether it is passed on as payload and, on the last byte, the verdict.
// ----------------------------------------------------------------------------
module upf_parser #(
  parameter int PAYLOAD_MAX       = upf_pkg::PAYLOAD_MAX_DEFAULT,
  parameter int LINK_HEADER_BYTES = upf_pkg::LINK_HEADER_BYTES_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               accept,
  input  wire upf_pkg::frame_t                    frame,
  input  wire logic                               cfg_write,
  input  wire logic [upf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [upf_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                    rec_write,
  output upf_pkg::rec_t                           rec
);
  import upf_pkg::*;

  localparam int MLEN_W = $clog2(PAYLOAD_MAX);
  localparam logic [15:0] LINK_POS  = 16'(LINK_HEADER_BYTES);
  localparam logic [15:0] PROTO_POS = 16'(LINK_HEADER_BYTES + 9);
  localparam logic [16:0] MIN_LEN   = 17'(LINK_HEADER_BYTES + 28);

  // configuration registers
  logic [15:0] match_port;
  logic [7:0]  match_protocol;

  // per-frame state
  logic [15:0]       pos;
  logic              hdr_ok;
  logic [15:0]       udp_pos;
  logic [15:0]       off_pos;
  logic [7:0]        proto;
  logic [15:0]       port;
  logic [15:0]       ulen;
  logic [MLEN_W-1:0] mlen;

  logic [15:0]       pos_next;
  logic              hdr_ok_next;
  logic [15:0]       udp_pos_next;
  logic [15:0]       off_pos_next;
  logic [7:0]        proto_next;
  logic [15:0]       port_next;
  logic [15:0]       ulen_next;
  logic [MLEN_W-1:0] mlen_next;

  logic [7:0]        b;
  logic [5:0]        ihl_new;
  logic              in_udp;
  logic              pass;
  logic [16:0]       len;
  logic [15:0]       port_eff;
  logic [MLEN_W-1:0] mlen_eff;
  logic [2:0]        verdict;
  logic [15:0]       mlen_wide;

  assign b       = frame.frame_byte;
  assign ihl_new = {b[3:0], 2'b00};
  assign in_udp  = (pos > LINK_POS) && hdr_ok;

  // header field capture
  always_comb begin
    pos_next     = (pos == 16'hffff) ? pos : pos + 16'd1;
    hdr_ok_next  = hdr_ok;
    udp_pos_next = udp_pos;
    off_pos_next = off_pos;
    proto_next   = proto;
    port_next    = port;
    ulen_next    = ulen;
    mlen_next    = mlen;
    if (pos == LINK_POS) begin
      hdr_ok_next  = (ihl_new >= 6'd20) && (ihl_new <= 6'd60);
      udp_pos_next = LINK_POS + 16'(ihl_new);
      off_pos_next = LINK_POS + 16'(ihl_new) + 16'd8;
    end
    if (pos == PROTO_POS) begin
      proto_next = b;
    end
    if (in_udp) begin
      if (pos == udp_pos) begin
        port_next = {b, 8'h00};
      end else if (pos == udp_pos + 16'd1) begin
        port_next = {port[15:8], b};
      end else if (pos == udp_pos + 16'd4) begin
        ulen_next = {b, 8'h00};
      end else if (pos == udp_pos + 16'd5) begin
        ulen_next = {ulen[15:8], b};
        mlen_next = (ulen_next > 16'd8) ? MLEN_W'(ulen_next - 16'd8) : '0;
      end
    end
  end

  // payload window check
  assign pass = in_udp && (proto == match_protocol) && (port == match_port)
             && (mlen != '0) && (pos >= off_pos)
             && ({1'b0, pos} < ({1'b0, off_pos} + 17'(mlen)));

  // end-of-frame verdict in order of checks
  assign len      = {1'b0, pos} + 17'd1;
  assign port_eff = (len >= {1'b0, udp_pos} + 17'd2) ? port_next : 16'd0;
  assign mlen_eff = (len >= {1'b0, udp_pos} + 17'd6) ? mlen_next : '0;
  assign mlen_wide = 16'(mlen_eff);

  always_comb begin
    if (len < MIN_LEN) begin
      verdict = VERDICT_SHORT;
    end else if (proto_next != match_protocol) begin
      verdict = VERDICT_PROTOCOL;
    end else if (!hdr_ok_next) begin
      verdict = VERDICT_HDR_LENGTH;
    end else if (port_eff != match_port) begin
      verdict = VERDICT_PORT;
    end else if (mlen_eff == '0) begin
      verdict = VERDICT_EMPTY;
    end else if (len < ({1'b0, off_pos} + 17'(mlen_eff))) begin
      verdict = VERDICT_TRUNCATED;
    end else begin
      verdict = VERDICT_ACCEPTED;
    end
  end

  // record for the queue
  always_comb begin
    rec_write          = accept && (pass || frame.frame_end);
    rec.has_payload    = pass;
    rec.payload_byte   = pass ? b : 8'd0;
    rec.has_verdict    = frame.frame_end;
    rec.verdict        = frame.frame_end ? verdict : VERDICT_ACCEPTED;
    rec.payload_length = (frame.frame_end && ((verdict == VERDICT_ACCEPTED)
                         || (verdict == VERDICT_TRUNCATED))) ? mlen_wide[8:0] : 9'd0;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      match_port     <= MATCH_PORT_RESET;
      match_protocol <= MATCH_PROTOCOL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MATCH_PORT:     match_port     <= cfg_data;
        CFG_MATCH_PROTOCOL: match_protocol <= cfg_data[7:0];
        default:            ;
      endcase
    end
  end

  // frame state, cleared after every frame end
  always_ff @(posedge clk) begin
    if (rst || (accept && frame.frame_end)) begin
      pos     <= 16'd0;
      hdr_ok  <= 1'b0;
      udp_pos <= LINK_POS;
      off_pos <= LINK_POS + 16'd8;
      proto   <= 8'd0;
      port    <= 16'd0;
      ulen    <= 16'd0;
      mlen    <= '0;
    end else if (accept) begin
      pos     <= pos_next;
      hdr_ok  <= hdr_ok_next;
      udp_pos <= udp_pos_next;
      off_pos <= off_pos_next;
      proto   <= proto_next;
      port    <= port_next;
      ulen    <= ulen_next;
      mlen    <= mlen_next;
    end
  end

`ifndef NO_ASSERTIONS
  // a frame end restarts the byte count
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && frame.frame_end |=> pos == 16'd0)
    else $error("byte position not cleared after frame end");

  // payload never passes outside a good header
  a_pass_hdr: assert property (@(posedge clk) disable iff (rst)
    pass |-> hdr_ok && (mlen != '0))
    else $error("payload passed without a valid header");
`endif

endmodule
`default_nettype wire

>>> rtl/upf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upf_queue: record queue between parser and emitter
// Small circular buffer of parser records so that either side may stall.
// ----------------------------------------------------------------------------
module upf_queue #(
  parameter int DEPTH = upf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire upf_pkg::rec_t wr_rec,
  output logic               full,
  input  wire logic          rd_en,
  output upf_pkg::head_t     head
);
  import upf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  rec_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head.valid = (count != '0);
  assign head.rec   = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_ONE;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_ONE;
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_ONE;
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_ONE;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // no overflow and no underflow
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && full) && !(rd_en && !head.valid))
    else $error("queue written when full or read when empty");
`endif

endmodule
`default_nettype wire

>>> rtl/upf_emitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upf_emitter: result item emitter
// Turns the head record into one or two result items, payload byte first.
// ----------------------------------------------------------------------------
module upf_emitter (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire upf_pkg::head_t  head,
  output logic                 rd_en,
  output logic                 empty,
  input  wire logic            pop,
  output upf_pkg::result_t     result
);
  import upf_pkg::*;

  // set once the payload half of a two-item record has been taken
  logic sent_payload;
  logic show_payload;
  logic take;

  assign empty        = !head.valid;
  assign show_payload = head.rec.has_payload && !sent_payload;
  assign take         = pop && head.valid;

  // result item from the head record
  always_comb begin
    result.item_kind      = show_payload ? ITEM_PAYLOAD : ITEM_VERDICT;
    result.payload_byte   = show_payload ? head.rec.payload_byte : 8'd0;
    result.verdict        = show_payload ? VERDICT_ACCEPTED : head.rec.verdict;
    result.payload_length = show_payload ? 9'd0 : head.rec.payload_length;
    result.run_last       = !show_payload;
  end

  // record retires after its last item
  assign rd_en = take && !(show_payload && head.rec.has_verdict);

  always_ff @(posedge clk) begin
    if (rst) begin
      sent_payload <= 1'b0;
    end else if (take) begin
      sent_payload <= show_payload && head.rec.has_verdict;
    end
  end

`ifndef NO_ASSERTIONS
  // a split record is waiting only for its verdict
  a_split_head: assert property (@(posedge clk) disable iff (rst)
    sent_payload |-> head.valid && head.rec.has_verdict)
    else $error("split record without a pending verdict");

  // the verdict item is the one that closes a run
  a_run_last: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.run_last == result.item_kind))
    else $error("run_last does not match item kind");
`endif

endmodule
`default_nettype wire

>>> rtl/udp_source_port_payload_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udp_source_port_payload_filter: udp source port filter and payload extractor
// Input queue port: push a frame byte with frame_end on its last byte while
// full is low; one byte is taken every cycle. The parser classifies the byte
// at once and writes a record into a small queue; the emitter reads it.
// Result queue port: while empty is low the oldest item is on result; pop
// takes it. Payload bytes inside the UDP payload window come out as they
// arrive; the last byte of every frame adds one verdict item (run_last high).
// The input takes one byte per cycle while full is low; a byte that yields
// both a payload item and a verdict needs two pops. When the receiver stalls
// the queue fills and full rises. Reset (rst, synchronous) empties the queue,
// clears the frame state and loads the match registers with port 53 and
// protocol 17. The user writes the registers through cfg_write, cfg_index
// and cfg_data only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module udp_source_port_payload_filter #(
  parameter int PAYLOAD_MAX       = upf_pkg::PAYLOAD_MAX_DEFAULT,
  parameter int LINK_HEADER_BYTES = upf_pkg::LINK_HEADER_BYTES_DEFAULT,
  parameter int QUEUE_DEPTH       = upf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire upf_pkg::frame_t                 frame,
  output logic                                 empty,
  input  wire logic                            pop,
  output upf_pkg::result_t                     result,
  input  wire logic                            cfg_write,
  input  wire logic [upf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [upf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import upf_pkg::*;

  logic  accept;
  logic  rec_write;
  rec_t  rec;
  head_t head;
  logic  rd_en;

  assign accept = push && !full;

  // front: parse and classify
  upf_parser #(
    .PAYLOAD_MAX       (PAYLOAD_MAX),
    .LINK_HEADER_BYTES (LINK_HEADER_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .frame     (frame),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rec_write (rec_write),
    .rec       (rec)
  );

  // decoupling queue
  upf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (rec_write),
    .wr_rec (rec),
    .full   (full),
    .rd_en  (rd_en),
    .head   (head)
  );

  // back: emit result items
  upf_emitter u_emitter (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .rd_en  (rd_en),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule
`default_nettype wire

>>> dv/udp_source_port_payload_filter_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udp_source_port_payload_filter_tb: self-checking bench for the udp filter
// Frames go in byte by byte from a queue. Each accepted byte passes through a
// behavioral copy of the parser, which queues the payload and verdict items
// the block should return. Popped items are checked in order against that
// queue. Directed frames hit every verdict and the header corner cases, and
// random frames follow under several match settings. The sender and the
// receiver stall at random in the first phases and run at full rate in the
// last phase.
// ----------------------------------------------------------------------------
module udp_source_port_payload_filter_tb;
  import upf_pkg::*;

  localparam int LHB           = LINK_HEADER_BYTES_DEFAULT;
  localparam int PMAX          = PAYLOAD_MAX_DEFAULT;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 4000;
  localparam int MAX_REPORTS   = 20;
  localparam int RANDOM_BUDGET = 70;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   push      = 1'b0;
  logic                   full;
  frame_t                 frame     = '0;
  logic                   empty;
  logic                   pop       = 1'b0;
  result_t                result;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  udp_source_port_payload_filter dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .frame     (frame),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // stimulus and expectation stores
  frame_t  bytes_to_send [$];
  result_t results_due [$];
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      fail_count    = 0;
  int      bytes_sent    = 0;
  int      payload_seen  = 0;
  int      verdict_hist [8];
  int      stall_cycles  = 0;

  // parser copy: match registers and per-frame state
  logic [15:0] want_port  = MATCH_PORT_RESET;
  logic [7:0]  want_proto = MATCH_PROTOCOL_RESET;
  int unsigned at_byte    = 0;
  int unsigned proto_seen = 0;
  int unsigned ihl_bytes  = 0;
  int unsigned sport_seen = 0;
  int unsigned ulen_seen  = 0;
  int unsigned window_len = 0;

  function automatic bit ihl_valid();
    return ihl_bytes >= 20 && ihl_bytes <= 60;
  endfunction

  // advance the parser copy by one byte and queue what it should emit
  function automatic void predict_filter(input frame_t f);
    int unsigned b, p, udp, off, n_len, port_val, mlen;
    logic [2:0]  v;
    result_t     r;
    b   = f.frame_byte;
    p   = at_byte;
    udp = LHB + ihl_bytes;
    off = udp + 8;
    if (p == LHB) ihl_bytes = (b & 'h0f) * 4;
    if (p == LHB + 9) proto_seen = b;
    // udp header fields, only once the ip header length is sane
    if (p > LHB && ihl_valid()) begin
      if (p == udp) sport_seen = (b << 8) & 'hff00;
      else if (p == udp + 1) sport_seen = (sport_seen & 'hff00) | b;
      else if (p == udp + 4) ulen_seen = (b << 8) & 'hff00;
      else if (p == udp + 5) begin
        ulen_seen  = (ulen_seen & 'hff00) | b;
        window_len = ulen_seen > 8 ? ((ulen_seen - 8) & (PMAX - 1)) : 0;
      end
    end
    // payload window
    if (p > LHB && ihl_valid() && proto_seen == want_proto && sport_seen == want_port
        && window_len != 0 && p >= off && p < off + window_len) begin
      r              = '0;
      r.item_kind    = ITEM_PAYLOAD;
      r.payload_byte = f.frame_byte;
      results_due.push_back(r);
    end
    if (p < 65535) at_byte = p + 1;
    // verdict on the last byte, checks in fixed order
    if (f.frame_end) begin
      n_len    = p + 1;
      port_val = n_len >= udp + 2 ? sport_seen : 0;
      mlen     = n_len >= udp + 6 ? window_len : 0;
      if (n_len < LHB + 28) v = VERDICT_SHORT;
      else if (proto_seen != want_proto) v = VERDICT_PROTOCOL;
      else if (!ihl_valid()) v = VERDICT_HDR_LENGTH;
      else if (port_val != want_port) v = VERDICT_PORT;
      else if (mlen == 0) v = VERDICT_EMPTY;
      else if (n_len < off + mlen) v = VERDICT_TRUNCATED;
      else v = VERDICT_ACCEPTED;
      r                = '0;
      r.item_kind      = ITEM_VERDICT;
      r.verdict        = v;
      r.payload_length = (v == VERDICT_ACCEPTED || v == VERDICT_TRUNCATED) ?
                         9'(mlen & 'h1ff) : 9'd0;
      r.run_last       = 1'b1;
      results_due.push_back(r);
      at_byte    = 0;
      proto_seen = 0;
      ihl_bytes  = 0;
      sport_seen = 0;
      ulen_seen  = 0;
      window_len = 0;
    end
  endfunction

  // frame length that exactly covers the udp payload window
  function automatic int natural_len(input logic [3:0] ihl_nib, input logic [15:0] ulen);
    return LHB + ihl_nib * 4 + 8 + (ulen > 8 ? ((ulen - 8) & (PMAX - 1)) : 0);
  endfunction

  // build one frame with the given header fields over random filler
  function automatic void queue_frame(input logic [3:0] ihl_nib, input logic [7:0] proto,
                                      input logic [15:0] sport, input logic [15:0] ulen,
                                      input int total_len);
    logic [7:0] fb [$];
    int         udp;
    frame_t     f;
    udp = LHB + ihl_nib * 4;
    for (int i = 0; i < total_len; i++) fb.push_back(8'($urandom));
    if (udp < total_len)     fb[udp]     = sport[15:8];
    if (udp + 1 < total_len) fb[udp + 1] = sport[7:0];
    if (udp + 4 < total_len) fb[udp + 4] = ulen[15:8];
    if (udp + 5 < total_len) fb[udp + 5] = ulen[7:0];
    if (LHB + 9 < total_len) fb[LHB + 9] = proto;
    if (LHB < total_len)     fb[LHB]     = {fb[LHB][7:4], ihl_nib};
    for (int i = 0; i < total_len; i++) begin
      f.frame_byte = fb[i];
      f.frame_end  = (i == total_len - 1);
      bytes_to_send.push_back(f);
    end
  endfunction

  // mostly well-formed frames, some cut short or padded, the rest broken or noise
  function automatic int queue_random_frame();
    int          r, k, len, nat;
    logic [3:0]  nib;
    logic [7:0]  pr;
    logic [15:0] sp, ul;
    r   = $urandom_range(99);
    k   = $urandom_range(19);
    nib = $urandom_range(1) ? 4'd5 : 4'($urandom_range(5, 15));
    pr  = $urandom_range(9) != 0 ? want_proto : 8'($urandom);
    sp  = $urandom_range(19) > 2 ? want_port : 16'($urandom);
    if (k < 18) ul = 16'($urandom_range(9, 40));
    else if (k == 18) ul = 16'($urandom);
    else ul = 16'($urandom_range(0, 8));
    nat = natural_len(nib, ul);
    if (r < 60) len = nat;
    else if (r < 72) len = $urandom_range(1, nat - 1);
    else if (r < 80) len = nat + $urandom_range(1, 6);
    else if (r < 92) begin
      nib = 4'($urandom);
      len = $urandom_range(1, 100);
    end else begin
      nib = 4'($urandom);
      pr  = 8'($urandom);
      sp  = 16'($urandom);
      ul  = 16'($urandom);
      len = $urandom_range(1, 80);
    end
    queue_frame(nib, pr, sp, ul, len);
    return len;
  endfunction

  function automatic void fill_random(input int budget);
    int queued;
    queued = 0;
    while (queued < budget) queued += queue_random_frame();
  endfunction

  // wait until every byte is in and every item is out, then let the pipe drain
  task automatic settle();
    do @(negedge clk);
    while (bytes_to_send.size() != 0 || push || results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write both match registers while the block is idle
  task automatic set_match(input logic [15:0] port, input logic [7:0] proto);
    @(posedge clk);
    cfg_write  <= 1'b1;
    cfg_index  <= CFG_MATCH_PORT;
    cfg_data   <= port;
    want_port  = port;
    @(posedge clk);
    cfg_index  <= CFG_MATCH_PROTOCOL;
    cfg_data   <= {8'($urandom), proto};
    want_proto = proto;
    @(posedge clk);
    cfg_write  <= 1'b0;
    @(negedge clk);
  endtask

  // driver: next item from the send queue, held while full
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_filter(frame);
        bytes_sent++;
      end
      if (!push || !full) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          frame <= bytes_to_send.pop_front();
          push  <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: check each popped item against the oldest expectation
  always @(posedge clk) begin
    result_t exp_item;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected item kind=%0d byte=%02h verdict=%0d len=%0d last=%0d",
                     $time, result.item_kind, result.payload_byte, result.verdict,
                     result.payload_length, result.run_last);
        end else begin
          exp_item = results_due.pop_front();
          if (result.item_kind !== exp_item.item_kind
              || result.payload_byte !== exp_item.payload_byte
              || result.verdict !== exp_item.verdict
              || result.payload_length !== exp_item.payload_length
              || result.run_last !== exp_item.run_last) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: mismatch expected kind=%0d byte=%02h verdict=%0d len=%0d last=%0d, %s",
                       $time, exp_item.item_kind, exp_item.payload_byte, exp_item.verdict,
                       exp_item.payload_length, exp_item.run_last,
                       $sformatf("actual kind=%0d byte=%02h verdict=%0d len=%0d last=%0d",
                                 result.item_kind, result.payload_byte, result.verdict,
                                 result.payload_length, result.run_last));
          end else if (exp_item.item_kind == ITEM_VERDICT) begin
            verdict_hist[exp_item.verdict]++;
          end else begin
            payload_seen++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d items still due",
                 $time, STALL_LIMIT, results_due.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    do @(negedge clk);
    while (rst);

    // default match settings, directed frames first
    send_idle_pct = 34;
    recv_idle_pct = 62;
    queue_frame(4'd5, 8'd17, 16'd53, 16'd12, 1);
    queue_frame(4'd5, 8'd17, 16'd53, 16'd12, LHB + 27);
    queue_frame(4'd5, 8'd17, 16'd53, 16'd12, natural_len(4'd5, 16'd12));
    queue_frame(4'd15, 8'd17, 16'd53, 16'd17, natural_len(4'd15, 16'd17) + 3);
    queue_frame(4'd5, 8'd6, 16'd53, 16'd12, natural_len(4'd5, 16'd12));
    queue_frame(4'd4, 8'd17, 16'd53, 16'd12, 60);
    queue_frame(4'd0, 8'd17, 16'd53, 16'd12, 60);
    queue_frame(4'd5, 8'd17, 16'd54, 16'd12, natural_len(4'd5, 16'd12));
    queue_frame(4'd5, 8'd17, 16'd53, 16'd8, 50);
    queue_frame(4'd5, 8'd17, 16'd53, 16'd0, 50);
    queue_frame(4'd5, 8'd17, 16'd53, 16'd520, 60);
    queue_frame(4'd5, 8'd17, 16'd53, 16'd519, natural_len(4'd5, 16'd519));
    queue_frame(4'd5, 8'd17, 16'd53, 16'd28, natural_len(4'd5, 16'd28) - 5);
    // frame ends after the port but before the length arrives
    queue_frame(4'd15, 8'd17, 16'd53, 16'd20, LHB + 63);
    // frame ends inside the port
    queue_frame(4'd15, 8'd17, 16'd53, 16'd20, LHB + 61);
    fill_random(RANDOM_BUDGET);
    settle();

    // all-ones match values
    set_match(16'hffff, 8'hff);
    fill_random(RANDOM_BUDGET);
    settle();

    // zero match values: a port cut off by the frame end reads as zero
    send_idle_pct = 62;
    recv_idle_pct = 34;
    set_match(16'h0000, 8'h00);
    queue_frame(4'd15, 8'd0, 16'h1234, 16'd20, LHB + 61);
    queue_frame(4'd6, 8'd0, 16'h0000, 16'd30, natural_len(4'd6, 16'd30));
    fill_random(RANDOM_BUDGET);
    settle();

    set_match(16'($urandom), MATCH_PROTOCOL_RESET);
    fill_random(RANDOM_BUDGET);
    settle();

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_match(MATCH_PORT_RESET, MATCH_PROTOCOL_RESET);
    fill_random(RANDOM_BUDGET);
    settle();

    $display("%0d frame bytes sent, %0d payload items and %0d verdicts checked",
             bytes_sent, payload_seen,
             verdict_hist[0] + verdict_hist[1] + verdict_hist[2] + verdict_hist[3]
             + verdict_hist[4] + verdict_hist[5] + verdict_hist[6]);
    $display("verdicts: accepted %0d short %0d protocol %0d hdr %0d port %0d empty %0d trunc %0d",
             verdict_hist[0], verdict_hist[1], verdict_hist[2], verdict_hist[3],
             verdict_hist[4], verdict_hist[5], verdict_hist[6]);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
